/* sv/kncs_pkg.sv */
// Shared types, widths and codes of the k-nearest-center search core.
package kncs_pkg;

  localparam int unsigned COORD_W          = 16;
  localparam int unsigned DIST_W           = 2 * COORD_W + 1;
  localparam int unsigned KREG_W           = 4;
  localparam int unsigned OP_W             = 2;
  localparam int unsigned CFG_IDX_W        = 1;
  localparam int unsigned MAX_CENTERS_DEF  = 1024;
  localparam int unsigned MAX_NEIGHBORS_DEF = 8;
  localparam logic [KREG_W-1:0] KREG_RST   = 4'd4;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR        = 2'd0,
    OP_APPEND       = 2'd1,
    OP_QUERY_PIXEL  = 2'd2,
    OP_QUERY_CENTER = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_K_PIXEL  = 1'b0,
    REG_K_CENTER = 1'b1
  } reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REF_RD,
    ST_REF_CAP,
    ST_SCAN,
    ST_FLUSH,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic clear;
    logic shift;
  } ctl_t;

endpackage

/* sv/kncs_dist.sv */
// Pipelined squared Euclidean distance between a query point and a center.
module kncs_dist #(
  parameter int unsigned IDX_W = 10
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           vld_i,
  input  logic [IDX_W-1:0]               idx_i,
  input  logic [kncs_pkg::COORD_W-1:0]   cx_i,
  input  logic [kncs_pkg::COORD_W-1:0]   cy_i,
  input  logic [kncs_pkg::COORD_W-1:0]   qx_i,
  input  logic [kncs_pkg::COORD_W-1:0]   qy_i,
  output logic                           vld_o,
  output logic [IDX_W-1:0]               idx_o,
  output logic [kncs_pkg::DIST_W-1:0]    dist_o
);
  import kncs_pkg::*;

  localparam int unsigned SQ_W = 2 * COORD_W;

  logic                     s1_vld_q, s2_vld_q, s3_vld_q;
  logic [IDX_W-1:0]         s1_idx_q, s2_idx_q, s3_idx_q;
  logic [COORD_W-1:0]       adx_q, ady_q, adx_d, ady_d;
  logic [2*COORD_W-1:0]     sqx_q, sqy_q;
  logic [DIST_W-1:0]        dist_q;

  assign adx_d = (cx_i > qx_i) ? cx_i - qx_i : qx_i - cx_i;
  assign ady_d = (cy_i > qy_i) ? cy_i - qy_i : qy_i - cy_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= vld_i;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_idx_q <= idx_i;
    adx_q    <= adx_d;
    ady_q    <= ady_d;
    s2_idx_q <= s1_idx_q;
    sqx_q    <= SQ_W'(adx_q) * SQ_W'(adx_q);
    sqy_q    <= SQ_W'(ady_q) * SQ_W'(ady_q);
    s3_idx_q <= s2_idx_q;
    dist_q   <= DIST_W'(sqx_q) + DIST_W'(sqy_q);
  end

  assign vld_o  = s3_vld_q;
  assign idx_o  = s3_idx_q;
  assign dist_o = dist_q;

endmodule

/* sv/kncs_cell.sv */
// One slot of the sorted neighbor chain: keeps the better candidate, passes the other on.
module kncs_cell #(
  parameter int unsigned IDX_W = 10
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  kncs_pkg::ctl_t               ctl_i,
  input  logic                         in_vld_i,
  input  logic [kncs_pkg::DIST_W-1:0]  in_dist_i,
  input  logic [IDX_W-1:0]             in_idx_i,
  input  logic                         nxt_vld_i,
  input  logic [kncs_pkg::DIST_W-1:0]  nxt_dist_i,
  input  logic [IDX_W-1:0]             nxt_idx_i,
  output logic                         st_vld_o,
  output logic [kncs_pkg::DIST_W-1:0]  st_dist_o,
  output logic [IDX_W-1:0]             st_idx_o,
  output logic                         pass_vld_o,
  output logic [kncs_pkg::DIST_W-1:0]  pass_dist_o,
  output logic [IDX_W-1:0]             pass_idx_o
);
  import kncs_pkg::*;

  logic              st_vld_q, pass_vld_q;
  logic [DIST_W-1:0] st_dist_q, pass_dist_q;
  logic [IDX_W-1:0]  st_idx_q, pass_idx_q;
  logic              win;

  assign win = in_vld_i && (!st_vld_q || (in_dist_i < st_dist_q) ||
                            ((in_dist_i == st_dist_q) && (in_idx_i < st_idx_q)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_vld_q   <= 1'b0;
      pass_vld_q <= 1'b0;
    end else if (ctl_i.clear) begin
      st_vld_q   <= 1'b0;
      pass_vld_q <= 1'b0;
    end else if (ctl_i.shift) begin
      st_vld_q   <= nxt_vld_i;
      pass_vld_q <= 1'b0;
    end else if (win) begin
      st_vld_q   <= 1'b1;
      pass_vld_q <= st_vld_q;
    end else begin
      pass_vld_q <= in_vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.shift) begin
      st_dist_q <= nxt_dist_i;
      st_idx_q  <= nxt_idx_i;
    end else if (win) begin
      st_dist_q   <= in_dist_i;
      st_idx_q    <= in_idx_i;
      pass_dist_q <= st_dist_q;
      pass_idx_q  <= st_idx_q;
    end else begin
      pass_dist_q <= in_dist_i;
      pass_idx_q  <= in_idx_i;
    end
  end

  assign st_vld_o    = st_vld_q;
  assign st_dist_o   = st_dist_q;
  assign st_idx_o    = st_idx_q;
  assign pass_vld_o  = pass_vld_q;
  assign pass_dist_o = pass_dist_q;
  assign pass_idx_o  = pass_idx_q;

endmodule

/* sv/k_nearest_center_search_core.sv */
// Top level of the k-nearest-center search core: center table, scan control, sorter chain.
// Clear and append leave the core idle. A pixel query scans the N stored centers, then
// flushes and emits; a center query with a stored reference first reads that center.
// Results then leave one per cycle while the output is taken; the next word is accepted
// once the last result is loaded. The scan reads one center per cycle from the table port.
// Reset empties the table and sets both K registers to 4; table contents are not cleared.
module k_nearest_center_search_core #(
  parameter  int unsigned MAX_CENTERS   = kncs_pkg::MAX_CENTERS_DEF,
  parameter  int unsigned MAX_NEIGHBORS = kncs_pkg::MAX_NEIGHBORS_DEF,
  localparam int unsigned IDX_W      = $clog2(MAX_CENTERS),
  localparam int unsigned RANK_W     = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1,
  localparam int unsigned IN_DATA_W  = ((2 * kncs_pkg::COORD_W + IDX_W + 7) / 8) * 8,
  localparam int unsigned OUT_DATA_W = ((IDX_W + RANK_W + kncs_pkg::DIST_W + 7) / 8) * 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // pos_x, pos_y, center_ref
  input  logic [IN_DATA_W-1:0]              s_axis_tdata,
  // op
  input  logic [kncs_pkg::OP_W-1:0]         s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // neighbor_index, rank, distance_sq
  output logic [OUT_DATA_W-1:0]             m_axis_tdata,
  // found
  output logic                              m_axis_tuser,
  output logic                              m_axis_tlast,
  input  logic                              cfg_we_i,
  input  logic [kncs_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [kncs_pkg::KREG_W-1:0]       cfg_data_i
);
  import kncs_pkg::*;

  localparam int unsigned CNT_W     = $clog2(MAX_CENTERS + 1);
  localparam int unsigned KW        = $clog2(MAX_NEIGHBORS + 1);
  localparam int unsigned FLUSH_CYC = MAX_NEIGHBORS + 4;
  localparam int unsigned FL_W      = $clog2(FLUSH_CYC + 1);

  state_e                state_q, state_d;
  logic [CNT_W-1:0]      cnt_q, scan_q;
  logic [KREG_W-1:0]     kpix_q, kctr_q, k_raw;
  logic [KW-1:0]         k_q, k_clamp;
  logic                  center_q;
  logic [IDX_W-1:0]      ref_q, rd_addr, rd_idx_q;
  logic [COORD_W-1:0]    qx_q, qy_q;
  logic [FL_W-1:0]       flush_q;
  logic [RANK_W-1:0]     rank_q;

  logic [2*COORD_W-1:0]  mem [MAX_CENTERS];
  logic [2*COORD_W-1:0]  rd_q;
  logic                  rd_vld_q, scan_vld;

  logic                  out_vld_q, out_found_q, out_last_q;
  logic [IDX_W-1:0]      out_idx_q;
  logic [RANK_W-1:0]     out_rank_q;
  logic [DIST_W-1:0]     out_dist_q;

  logic                  in_acc, load_out, last_item;
  op_e                   op;
  ctl_t                  ctl;

  logic [COORD_W-1:0]    in_x, in_y;
  logic [IDX_W-1:0]      in_ref;

  logic                  dist_vld;
  logic [IDX_W-1:0]      dist_idx;
  logic [DIST_W-1:0]     dist_val;

  logic                  c_vld  [MAX_NEIGHBORS+1];
  logic [DIST_W-1:0]     c_dist [MAX_NEIGHBORS+1];
  logic [IDX_W-1:0]      c_idx  [MAX_NEIGHBORS+1];
  logic                  s_vld  [MAX_NEIGHBORS+1];
  logic [DIST_W-1:0]     s_dist [MAX_NEIGHBORS+1];
  logic [IDX_W-1:0]      s_idx  [MAX_NEIGHBORS+1];

  assign in_x   = s_axis_tdata[COORD_W-1:0];
  assign in_y   = s_axis_tdata[2*COORD_W-1:COORD_W];
  assign in_ref = s_axis_tdata[2*COORD_W +: IDX_W];
  assign op     = op_e'(s_axis_tuser);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign k_raw   = (op == OP_QUERY_PIXEL) ? kpix_q : kctr_q;
  assign k_clamp = (k_raw == '0) ? KW'(1) :
                   (int'(k_raw) > int'(MAX_NEIGHBORS)) ? KW'(MAX_NEIGHBORS) : KW'(k_raw);

  assign rd_addr  = (state_q == ST_REF_RD) ? ref_q : scan_q[IDX_W-1:0];
  assign scan_vld = (state_q == ST_SCAN) && !(center_q && (scan_q[IDX_W-1:0] == ref_q));

  assign last_item = !s_vld[0] || !s_vld[1] || (KW'(rank_q) == k_q - KW'(1));

  always_comb begin
    state_d   = state_q;
    load_out  = 1'b0;
    ctl.clear = 1'b0;
    ctl.shift = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (op)
            OP_CLEAR, OP_APPEND: state_d = ST_IDLE;
            OP_QUERY_PIXEL: begin
              ctl.clear = 1'b1;
              state_d   = (cnt_q == '0) ? ST_FLUSH : ST_SCAN;
            end
            OP_QUERY_CENTER: begin
              ctl.clear = 1'b1;
              state_d   = (CNT_W'(in_ref) >= cnt_q) ? ST_EMIT : ST_REF_RD;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_REF_RD:  state_d = ST_REF_CAP;
      ST_REF_CAP: state_d = ST_SCAN;
      ST_SCAN: begin
        if (scan_q == cnt_q - CNT_W'(1)) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (flush_q == FL_W'(FLUSH_CYC - 1)) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_vld_q || m_axis_tready) begin
          load_out  = 1'b1;
          ctl.shift = 1'b1;
          if (last_item) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      kpix_q   <= KREG_RST;
      kctr_q   <= KREG_RST;
      rd_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= scan_vld;
      if (cfg_we_i) begin
        unique case (reg_e'(cfg_idx_i))
          REG_K_PIXEL:  kpix_q <= cfg_data_i;
          REG_K_CENTER: kctr_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_acc && (op == OP_CLEAR)) begin
        cnt_q <= '0;
      end else if (in_acc && (op == OP_APPEND) && (cnt_q < CNT_W'(MAX_CENTERS))) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
      if (load_out) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && (op == OP_APPEND) && (cnt_q < CNT_W'(MAX_CENTERS))) begin
      mem[cnt_q[IDX_W-1:0]] <= {in_y, in_x};
    end
    rd_q     <= mem[rd_addr];
    rd_idx_q <= rd_addr;
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      k_q      <= k_clamp;
      center_q <= (op == OP_QUERY_CENTER);
      ref_q    <= in_ref;
      qx_q     <= in_x;
      qy_q     <= in_y;
      scan_q   <= '0;
      flush_q  <= '0;
      rank_q   <= '0;
    end
    if (state_q == ST_REF_CAP) begin
      qx_q <= rd_q[COORD_W-1:0];
      qy_q <= rd_q[2*COORD_W-1:COORD_W];
    end
    if (state_q == ST_SCAN) begin
      scan_q <= scan_q + CNT_W'(1);
    end
    if (state_q == ST_FLUSH) begin
      flush_q <= flush_q + FL_W'(1);
    end
    if (load_out) begin
      rank_q      <= rank_q + RANK_W'(1);
      out_found_q <= s_vld[0];
      out_last_q  <= last_item;
      out_idx_q   <= s_vld[0] ? s_idx[0]  : '0;
      out_dist_q  <= s_vld[0] ? s_dist[0] : '0;
      out_rank_q  <= s_vld[0] ? rank_q    : '0;
    end
  end

  kncs_dist #(
    .IDX_W (IDX_W)
  ) u_dist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (rd_vld_q),
    .idx_i  (rd_idx_q),
    .cx_i   (rd_q[COORD_W-1:0]),
    .cy_i   (rd_q[2*COORD_W-1:COORD_W]),
    .qx_i   (qx_q),
    .qy_i   (qy_q),
    .vld_o  (dist_vld),
    .idx_o  (dist_idx),
    .dist_o (dist_val)
  );

  assign c_vld[0]  = dist_vld;
  assign c_dist[0] = dist_val;
  assign c_idx[0]  = dist_idx;

  assign s_vld[MAX_NEIGHBORS]  = 1'b0;
  assign s_dist[MAX_NEIGHBORS] = '0;
  assign s_idx[MAX_NEIGHBORS]  = '0;

  for (genvar i = 0; i < MAX_NEIGHBORS; i++) begin : g_cell
    kncs_cell #(
      .IDX_W (IDX_W)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl),
      .in_vld_i    (c_vld[i]),
      .in_dist_i   (c_dist[i]),
      .in_idx_i    (c_idx[i]),
      .nxt_vld_i   (s_vld[i+1]),
      .nxt_dist_i  (s_dist[i+1]),
      .nxt_idx_i   (s_idx[i+1]),
      .st_vld_o    (s_vld[i]),
      .st_dist_o   (s_dist[i]),
      .st_idx_o    (s_idx[i]),
      .pass_vld_o  (c_vld[i+1]),
      .pass_dist_o (c_dist[i+1]),
      .pass_idx_o  (c_idx[i+1])
    );
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = OUT_DATA_W'({out_dist_q, out_rank_q, out_idx_q});
  assign m_axis_tuser  = out_found_q;
  assign m_axis_tlast  = out_last_q;

  a_notfound_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tlast && (out_rank_q == '0)))
    else $error("not-found result without last or with nonzero rank");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_CENTERS))
    else $error("center count beyond table depth");

  a_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (!dist_vld && !c_vld[MAX_NEIGHBORS - 1]))
    else $error("distance pipeline not drained before emitting");

  a_packed_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_vld[1] |-> s_vld[0])
    else $error("gap in sorted neighbor chain");

endmodule

/* tb/sv/testbench.sv */
// Self-checking testbench of the k-nearest-center search core: streams table and query words.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import kncs_pkg::*;

  localparam int unsigned IDX_BITS = 10;
  localparam int unsigned IN_W     = ((2 * COORD_W + IDX_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_W    = ((IDX_BITS + 3 + DIST_W + 7) / 8) * 8;
  localparam int unsigned TBL_MAX  = MAX_CENTERS_DEF;
  localparam int unsigned K_MAX    = MAX_NEIGHBORS_DEF;
  localparam int unsigned SETTLE   = 24;

  typedef struct packed {
    logic [IDX_BITS-1:0] idx;
    logic [2:0]          rank;
    logic [DIST_W-1:0]   dist_sq;
    logic                found;
    logic                last;
  } neighbor_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [IN_W-1:0]     s_axis_tdata  = '0;
  logic [OP_W-1:0]     s_axis_tuser  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OUT_W-1:0]    m_axis_tdata;
  logic                m_axis_tuser;
  logic                m_axis_tlast;
  logic                cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i    = '0;
  logic [KREG_W-1:0]   cfg_data_i    = '0;

  neighbor_t        expected_neighbors[$];
  logic [15:0]      tbl_x[TBL_MAX];
  logic [15:0]      tbl_y[TBL_MAX];
  int unsigned      tbl_count;
  logic [KREG_W-1:0] k_pixel;
  logic [KREG_W-1:0] k_center;
  int unsigned      mismatches;
  int unsigned      items_sent;
  int unsigned      hold_left;
  int unsigned      result_pause;
  bit               src_gaps;
  bit               sink_gaps;

  k_nearest_center_search_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void queue_result(neighbor_t w);
    expected_neighbors = {expected_neighbors, w};
  endfunction

  task automatic rank_nearest_centers(op_e op, logic [15:0] x, logic [15:0] y,
                                      logic [IDX_BITS-1:0] cref);
    logic [DIST_W-1:0] best_d[K_MAX];
    int unsigned       best_i[K_MAX];
    logic [15:0]       dx, dy;
    logic [DIST_W-1:0] d;
    logic [KREG_W-1:0] kv;
    logic [15:0]       qx, qy;
    int                n, p, k;
    bit                skip_self;
    neighbor_t         r;
    n = 0;
    qx = x;
    qy = y;
    skip_self = 1'b0;
    r = '0;
    r.last = 1'b1;
    case (op)
      OP_CLEAR: begin
        tbl_count = 0;
      end
      OP_APPEND: begin
        if (tbl_count < TBL_MAX) begin
          tbl_x[tbl_count] = x;
          tbl_y[tbl_count] = y;
          tbl_count++;
        end
      end
      default: begin
        kv = (op == OP_QUERY_PIXEL) ? k_pixel : k_center;
        k = (kv == 0) ? 1 : ((kv > K_MAX) ? K_MAX : kv);
        if (op == OP_QUERY_CENTER) begin
          if (cref < tbl_count) begin
            qx = tbl_x[cref];
            qy = tbl_y[cref];
            skip_self = 1'b1;
          end else begin
            queue_result(r);
            return;
          end
        end
        for (int j = 0; j < tbl_count; j++) begin
          if (!(skip_self && j == cref)) begin
            dx = (tbl_x[j] > qx) ? tbl_x[j] - qx : qx - tbl_x[j];
            dy = (tbl_y[j] > qy) ? tbl_y[j] - qy : qy - tbl_y[j];
            d = DIST_W'(dx) * DIST_W'(dx) + DIST_W'(dy) * DIST_W'(dy);
            p = n;
            while (p > 0 && best_d[p-1] > d) p--;
            if (p < k) begin
              if (n < k) n++;
              for (int q = n - 1; q > p; q--) begin
                best_d[q] = best_d[q-1];
                best_i[q] = best_i[q-1];
              end
              best_d[p] = d;
              best_i[p] = j;
            end
          end
        end
        if (n == 0) begin
          queue_result(r);
        end else begin
          for (int i = 0; i < n; i++) begin
            r.idx = IDX_BITS'(best_i[i]);
            r.rank = 3'(i);
            r.dist_sq = best_d[i];
            r.found = 1'b1;
            r.last = (i == n - 1);
            queue_result(r);
          end
        end
      end
    endcase
  endtask

  task automatic send_word(op_e op, logic [15:0] x, logic [15:0] y, logic [IDX_BITS-1:0] cref);
    int unsigned gap;
    gap = src_gaps ? $urandom_range(7) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= IN_W'({cref, y, x});
    s_axis_tuser <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
    rank_nearest_centers(op, x, y, cref);
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (expected_neighbors.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_k(reg_e which, logic [KREG_W-1:0] value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= which;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (which == REG_K_PIXEL) k_pixel = value;
    else k_center = value;
  endtask

  function automatic logic [15:0] pick_coord(bit clustered);
    if (clustered) return 16'($urandom_range(3) << 4);
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) result_pause = sink_gaps ? $urandom_range(7) : 0;
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (result_pause != 0) begin
      result_pause--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    neighbor_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_neighbors.size() == 0) begin
        $error("unexpected result word: tdata %h found %b last %b",
               m_axis_tdata, m_axis_tuser, m_axis_tlast);
        mismatches++;
      end else begin
        e = expected_neighbors.pop_front();
        if (m_axis_tdata[9:0] !== e.idx) begin
          $error("neighbor_index: expected %0d, got %0d", e.idx, m_axis_tdata[9:0]);
          mismatches++;
        end
        if (m_axis_tdata[12:10] !== e.rank) begin
          $error("rank: expected %0d, got %0d", e.rank, m_axis_tdata[12:10]);
          mismatches++;
        end
        if (m_axis_tdata[45:13] !== e.dist_sq) begin
          $error("distance_sq: expected %0d, got %0d", e.dist_sq, m_axis_tdata[45:13]);
          mismatches++;
        end
        if (m_axis_tuser !== e.found) begin
          $error("found: expected %0d, got %0d", e.found, m_axis_tuser);
          mismatches++;
        end
        if (m_axis_tlast !== e.last) begin
          $error("last: expected %0d, got %0d", e.last, m_axis_tlast);
          mismatches++;
        end
      end
    end
  end

  task automatic test_empty_table();
    send_word(OP_QUERY_PIXEL, 16'h0000, 16'h0000, '0);
    send_word(OP_QUERY_CENTER, 16'hFFFF, 16'hFFFF, '0);
    send_word(OP_QUERY_CENTER, 16'h0000, 16'h0000, 10'h3FF);
  endtask

  task automatic test_extremes();
    send_word(OP_APPEND, 16'h0000, 16'h0000, 10'h3FF);
    send_word(OP_QUERY_CENTER, 16'hFFFF, 16'hFFFF, 10'd0);
    send_word(OP_QUERY_PIXEL, 16'hFFFF, 16'hFFFF, 10'h3FF);
    send_word(OP_APPEND, 16'hFFFF, 16'hFFFF, 10'h3FF);
    send_word(OP_APPEND, 16'h0000, 16'h0000, 10'h000);
    send_word(OP_QUERY_PIXEL, 16'h0000, 16'h0000, 10'h3FF);
    send_word(OP_QUERY_CENTER, 16'h0000, 16'h0000, 10'd1);
    send_word(OP_QUERY_CENTER, 16'hFFFF, 16'hFFFF, 10'd3);
    send_word(OP_APPEND, 16'hFFFF, 16'h0000, 10'h155);
    send_word(OP_APPEND, 16'h0000, 16'hFFFF, 10'h2AA);
    send_word(OP_QUERY_PIXEL, 16'h8000, 16'h8000, 10'h000);
    send_word(OP_CLEAR, 16'hFFFF, 16'hFFFF, 10'h3FF);
    send_word(OP_QUERY_PIXEL, 16'h1234, 16'h5678, 10'h000);
  endtask

  task automatic test_k_settings();
    logic [KREG_W-1:0] k_pairs[3][2];
    k_pairs = '{'{4'd0, 4'd15}, '{4'd15, 4'd0}, '{4'd8, 4'd1}};
    send_word(OP_CLEAR, 16'h0000, 16'h0000, '0);
    for (int i = 0; i < 9; i++) send_word(OP_APPEND, 16'(i * 16), 16'(i * 3), '0);
    for (int i = 0; i < 3; i++) begin
      settle();
      write_k(REG_K_PIXEL, k_pairs[i][0]);
      write_k(REG_K_CENTER, k_pairs[i][1]);
      send_word(OP_QUERY_PIXEL, 16'h0000, 16'h0000, '0);
      send_word(OP_QUERY_CENTER, 16'h0000, 16'h0000, 10'd4);
    end
  endtask

  task automatic test_backpressure();
    settle();
    write_k(REG_K_PIXEL, 4'd8);
    write_k(REG_K_CENTER, 4'd8);
    src_gaps = 1'b0;
    send_word(OP_CLEAR, 16'h0000, 16'h0000, '0);
    repeat (12) send_word(OP_APPEND, pick_coord(1'b0), pick_coord(1'b0), '0);
    settle();
    @(negedge clk_i);
    hold_left = 400;
    @(posedge clk_i);
    for (int i = 0; i < 8; i++) begin
      if (i % 2 == 0) send_word(OP_QUERY_PIXEL, pick_coord(1'b0), pick_coord(1'b0), '0);
      else send_word(OP_QUERY_CENTER, 16'h0000, 16'h0000, 10'($urandom_range(11)));
    end
    settle();
  endtask

  task automatic test_random(int unsigned target);
    int unsigned set_no;
    bit          clustered;
    set_no = 0;
    while (items_sent < target) begin
      src_gaps = ($urandom_range(3) != 0);
      sink_gaps = ($urandom_range(3) != 0);
      if (set_no % 6 == 5) begin
        settle();
        write_k(REG_K_PIXEL, 4'($urandom_range(15)));
        write_k(REG_K_CENTER, 4'($urandom_range(15)));
      end
      set_no++;
      clustered = 1'($urandom_range(1));
      send_word(OP_CLEAR, 16'($urandom), 16'($urandom), 10'($urandom));
      repeat (($urandom_range(9) == 0) ? 0 : $urandom_range(1, 24))
        send_word(OP_APPEND, pick_coord(clustered), pick_coord(clustered), 10'($urandom));
      repeat ($urandom_range(1, 8)) begin
        case ($urandom_range(9))
          0: send_word(op_e'(2'($urandom_range(3))), 16'($urandom), 16'($urandom),
                       10'($urandom));
          1: send_word(OP_QUERY_CENTER, 16'($urandom), 16'($urandom),
                       10'((tbl_count >= TBL_MAX) ? $urandom : $urandom_range(1023, tbl_count)));
          2, 3, 4, 5: send_word(OP_QUERY_PIXEL, pick_coord(clustered), pick_coord(clustered),
                                10'($urandom));
          default: send_word(OP_QUERY_CENTER, 16'($urandom), 16'($urandom),
                             10'((tbl_count == 0) ? $urandom :
                                 $urandom_range(tbl_count - 1)));
        endcase
      end
    end
  endtask

  initial begin
    tbl_count = 0;
    k_pixel = KREG_RST;
    k_center = KREG_RST;
    mismatches = 0;
    items_sent = 0;
    hold_left = 0;
    result_pause = 0;
    src_gaps = 1'b1;
    sink_gaps = 1'b1;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_table();
    test_extremes();
    test_k_settings();
    test_backpressure();
    test_random(410);
    settle();
    repeat (64) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
